/* rtl/dcbb_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package dcbb_pkg;

    // fixed-point format of entries and outputs
    localparam int FRAC_BITS = 16;

    // square root: one result bit per stage
    localparam int ROOT_W   = 32;
    localparam int SQ_STEPS = ROOT_W;
    localparam int REM_W    = ROOT_W + 4;

    // division: numerator wide enough for a 34-bit magnitude shifted by 2F
    localparam int NUM_W     = (2 * FRAC_BITS + 34 > 66) ? 2 * FRAC_BITS + 34 : 66;
    localparam int QUO_W     = 63;
    localparam int HI_W      = NUM_W - QUO_W;
    localparam int DIV_STEPS = QUO_W;
    localparam int DIV_N     = 5;

    // divider lanes
    localparam int DV_VALUE  = 0;
    localparam int DV_DIAG   = 1;
    localparam int DV_OFFSET = 2;
    localparam int DV_T1     = 3;
    localparam int DV_T2     = 4;

    // register stages: select, products, sqrt (start + steps), prep,
    // divider (start + steps), output
    localparam int PIPE_N = 2 + (SQ_STEPS + 1) + 1 + (DIV_STEPS + 1) + 1;

    localparam logic [QUO_W-1:0] Q_CAP = QUO_W'(1) << 62;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_NEG_DISC   = 3'd1,
        ST_ZERO_SCALE = 3'd2,
        ST_ZERO_ROOT  = 3'd3,
        ST_SAT        = 3'd4
    } status_t;

    typedef struct packed {
        logic [1:0] k;
        logic       is_max;
        logic       want;
    } band_t;

    typedef struct packed {
        band_t       band;
        logic [31:0] d;
        logic [31:0] a;
        logic [31:0] s;
        logic        zs;
        logic        nd;
    } pre_t;

    typedef struct packed {
        band_t band;
        logic  zs;
        logic  nd;
        logic  fz;
    } post_t;

    typedef struct packed {
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
        logic [63:0]       rad;
    } sqrt_st_t;

    typedef struct packed {
        logic [63:0]      r;
        logic [QUO_W-1:0] q;
        logic [QUO_W-1:0] lo;
        logic [63:0]      dv;
        logic             big;
        logic             neg;
    } div_st_t;

    typedef struct packed {
        logic        sat;
        logic [31:0] v;
    } sat_t;

    // one digit of the restoring square root
    function automatic sqrt_st_t sqrt_step(input sqrt_st_t s);
        logic [REM_W-1:0] t;
        logic [REM_W-1:0] trial;
        sqrt_st_t         o;
        t     = {s.rem[REM_W-3:0], s.rad[63:62]};
        trial = {{(REM_W-ROOT_W-2){1'b0}}, s.root, 2'b01};
        o.rad = {s.rad[61:0], 2'b00};
        if (t >= trial) begin
            o.rem  = t - trial;
            o.root = {s.root[ROOT_W-2:0], 1'b1};
        end
        else begin
            o.rem  = t;
            o.root = {s.root[ROOT_W-2:0], 1'b0};
        end
        return o;
    endfunction

    // high part decides overflow of the quotient, low part is shifted in
    function automatic div_st_t div_start(input logic [NUM_W-1:0] num,
                                          input logic [63:0] dv, input logic neg);
        logic [63:0] hi;
        div_st_t     o;
        hi    = 64'(num[NUM_W-1:QUO_W]);
        o.big = (hi >= dv);
        o.r   = o.big ? 64'd0 : hi;
        o.q   = '0;
        o.lo  = num[QUO_W-1:0];
        o.dv  = dv;
        o.neg = neg;
        return o;
    endfunction

    // one quotient bit
    function automatic div_st_t div_step(input div_st_t d);
        logic [64:0] t;
        logic        qb;
        div_st_t     o;
        t  = {d.r, d.lo[QUO_W-1]};
        qb = (t >= {1'b0, d.dv});
        if (qb) begin
            t = t - {1'b0, d.dv};
        end
        o     = d;
        o.r   = t[63:0];
        o.q   = {d.q[QUO_W-2:0], qb};
        o.lo  = {d.lo[QUO_W-2:0], 1'b0};
        return o;
    endfunction

    // clamp quotient to 2^62 and apply sign
    function automatic logic [63:0] div_result(input div_st_t d);
        logic [QUO_W-1:0] q;
        logic [63:0]      v;
        if (d.big || (d.q[QUO_W-1] && (|d.q[QUO_W-2:0]))) begin
            q = Q_CAP;
        end
        else begin
            q = d.q;
        end
        v = {1'b0, q};
        return d.neg ? (64'd0 - v) : v;
    endfunction

    function automatic sat_t sat32(input logic [63:0] v);
        sat_t o;
        if ((v[63:31] == '0) || (v[63:31] == '1)) begin
            o.sat = 1'b0;
            o.v   = v[31:0];
        end
        else begin
            o.sat = 1'b1;
            o.v   = v[63] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
        return o;
    endfunction

    function automatic logic [31:0] mag32(input logic [31:0] v);
        return v[31] ? (~v + 32'd1) : v;
    endfunction

endpackage

`default_nettype wire

/* rtl/dual_conic_bounding_box.sv */
`timescale 1ns / 1ps
`default_nettype none

// channel   | handshake           | payload
// ----------+---------------------+------------------------------------------
// input     | in_valid / in_ready | c00 c11 c02 c12 c22 want_derivs
// result    | out_valid/out_ready | bound_index bound_value d_by_diag
//           |                     | d_by_offset d_by_scale status last
//
// One bound enters the pipeline per cycle unless the output stalls, so an item
// holds the input for its four bounds; the single result channel sets that
// rate. The first result of a transaction passes select, product, 33 square-root
// and 64 divider registers (a start register, then one bit per stage), prep and
// output. Reset clears the item and stage valid bits and the bound counter only.
// A stall at the output freezes the whole pipeline and an item already held.
module dual_conic_bounding_box
    import dcbb_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic signed [31:0] c00,
    input  wire logic signed [31:0] c11,
    input  wire logic signed [31:0] c02,
    input  wire logic signed [31:0] c12,
    input  wire logic signed [31:0] c22,
    input  wire logic               want_derivs,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [1:0]              bound_index,
    output logic signed [31:0]      bound_value,
    output logic signed [31:0]      d_by_diag,
    output logic signed [31:0]      d_by_offset,
    output logic signed [31:0]      d_by_scale,
    output logic [2:0]              status,
    output logic                    last
);

    // item register and bound counter
    logic        item_vld_reg, item_vld_next;
    logic [1:0]  k_reg, k_next;
    logic [31:0] c00_reg, c11_reg, c02_reg, c12_reg, c22_reg;
    logic        want_reg;

    logic [PIPE_N-1:0] vld_reg, vld_next;
    logic adv, issue, in_acc;

    assign adv      = !vld_reg[PIPE_N-1] || out_ready;
    assign issue    = item_vld_reg && adv;
    assign in_ready = !item_vld_reg || (adv && (k_reg == 2'd3));
    assign in_acc   = in_valid && in_ready;

    always_comb
    begin
        item_vld_next = item_vld_reg;
        k_next        = k_reg;
        if (in_acc)
        begin
            item_vld_next = 1'b1;
            k_next        = 2'd0;
        end
        else if (issue)
        begin
            k_next = k_reg + 2'd1;
            if (k_reg == 2'd3)
            begin
                item_vld_next = 1'b0;
            end
        end
        vld_next = adv ? {vld_reg[PIPE_N-2:0], issue} : vld_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_vld_reg <= 1'b0;
            k_reg        <= 2'd0;
            vld_reg      <= '0;
        end
        else
        begin
            item_vld_reg <= item_vld_next;
            k_reg        <= k_next;
            vld_reg      <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            c00_reg  <= c00;
            c11_reg  <= c11;
            c02_reg  <= c02;
            c12_reg  <= c12;
            c22_reg  <= c22;
            want_reg <= want_derivs;
        end
    end

    // pipeline payload registers
    pre_t        a_reg, b_reg;
    logic [63:0] b_aa_reg, b_sd_reg;
    sqrt_st_t    sq_st_reg   [0:SQ_STEPS];
    pre_t        sq_meta_reg [0:SQ_STEPS];
    post_t       d_meta_reg;
    logic [31:0] d_f_reg, d_sm_reg, d_magd_reg;
    logic        d_dneg_reg, d_sneg_reg;
    logic [33:0] d_n_reg, d_off_reg;
    logic [63:0] d_fs_reg, d_ss_reg;
    div_st_t     dv_reg      [0:DIV_STEPS][0:DIV_N-1];
    post_t       dv_meta_reg [0:DIV_STEPS];

    logic [1:0]  o_idx_reg;
    logic [31:0] o_val_reg, o_diag_reg, o_off_reg, o_scale_reg;
    status_t     o_st_reg;
    logic        o_last_reg;

    // select entries of the bound
    pre_t a_next;
    always_comb
    begin
        a_next.band.k      = k_reg;
        a_next.band.is_max = k_reg[1];
        a_next.band.want   = want_reg;
        a_next.d           = k_reg[0] ? c11_reg : c00_reg;
        a_next.a           = k_reg[0] ? c12_reg : c02_reg;
        a_next.s           = c22_reg;
        a_next.zs          = 1'b0;
        a_next.nd          = 1'b0;
    end

    // products a*a and s*d
    logic signed [63:0] aa, sd;
    assign aa = $signed(a_reg.a) * $signed(a_reg.a);
    assign sd = $signed(a_reg.s) * $signed(a_reg.d);

    // discriminant and square root start
    logic [64:0] disc;
    pre_t        c_meta;
    sqrt_st_t    sq_start;
    always_comb
    begin
        disc           = {b_aa_reg[63], b_aa_reg} - {b_sd_reg[63], b_sd_reg};
        c_meta         = b_reg;
        c_meta.zs      = (b_reg.s == 32'd0);
        c_meta.nd      = disc[64];
        sq_start.rem   = '0;
        sq_start.root  = '0;
        sq_start.rad   = disc[63:0];
    end

    // root, offsets and divisor products
    pre_t        sm_meta;
    logic [31:0] f, sm;
    logic [33:0] a34, f34, n34, off34;
    post_t       d_meta_next;
    always_comb
    begin
        sm_meta = sq_meta_reg[SQ_STEPS];
        f       = sq_st_reg[SQ_STEPS].root;
        sm      = mag32(sm_meta.s);
        a34     = {{2{sm_meta.a[31]}}, sm_meta.a};
        f34     = {2'b00, f};
        n34     = sm_meta.band.is_max ? (a34 - f34) : (a34 + f34);
        off34   = sm_meta.band.is_max ? (f34 - a34) : (f34 + a34);
        d_meta_next.band = sm_meta.band;
        d_meta_next.zs   = sm_meta.zs;
        d_meta_next.nd   = sm_meta.nd;
        d_meta_next.fz   = (f == 32'd0);
    end

    // divider operands
    div_st_t     dv_start [0:DIV_N-1];
    logic [33:0] mag_n, mag_off;
    logic        n_neg, off_neg, is_max_d;
    always_comb
    begin
        n_neg    = d_n_reg[33];
        off_neg  = d_off_reg[33];
        mag_n    = n_neg ? (~d_n_reg + 34'd1) : d_n_reg;
        mag_off  = off_neg ? (~d_off_reg + 34'd1) : d_off_reg;
        is_max_d = d_meta_reg.band.is_max;
        dv_start[DV_VALUE]  = div_start(NUM_W'(mag_n) << FRAC_BITS, 64'(d_sm_reg),
                                        n_neg ^ d_sneg_reg);
        dv_start[DV_DIAG]   = div_start(NUM_W'(1) << (2 * FRAC_BITS - 1), 64'(d_f_reg),
                                        !is_max_d);
        dv_start[DV_OFFSET] = div_start(NUM_W'(mag_off) << (2 * FRAC_BITS), d_fs_reg,
                                        off_neg ^ d_sneg_reg);
        dv_start[DV_T1]     = div_start(NUM_W'(mag_n) << (2 * FRAC_BITS), d_ss_reg,
                                        !n_neg && (d_n_reg != 34'd0));
        dv_start[DV_T2]     = div_start(NUM_W'(d_magd_reg) << (2 * FRAC_BITS),
                                        {d_fs_reg[62:0], 1'b0},
                                        (d_dneg_reg ^ d_sneg_reg) ^ !is_max_d);
    end

    // results, saturation and status
    post_t       fm;
    sat_t        r_val, r_diag, r_off, r_scale;
    logic [63:0] scale_sum;
    logic [31:0] val_next, diag_next, off_next, scale_next;
    status_t     st_next;
    always_comb
    begin
        fm        = dv_meta_reg[DIV_STEPS];
        r_val     = sat32(div_result(dv_reg[DIV_STEPS][DV_VALUE]));
        r_diag    = sat32(div_result(dv_reg[DIV_STEPS][DV_DIAG]));
        r_off     = sat32(div_result(dv_reg[DIV_STEPS][DV_OFFSET]));
        scale_sum = div_result(dv_reg[DIV_STEPS][DV_T1])
                  + div_result(dv_reg[DIV_STEPS][DV_T2]);
        r_scale   = sat32(scale_sum);
        val_next   = 32'd0;
        diag_next  = 32'd0;
        off_next   = 32'd0;
        scale_next = 32'd0;
        if (fm.zs)
        begin
            st_next = ST_ZERO_SCALE;
        end
        else if (fm.nd)
        begin
            st_next = ST_NEG_DISC;
        end
        else
        begin
            val_next = r_val.v;
            if (fm.band.want && fm.fz)
            begin
                st_next = ST_ZERO_ROOT;
            end
            else if (fm.band.want)
            begin
                diag_next  = r_diag.v;
                off_next   = r_off.v;
                scale_next = r_scale.v;
                st_next    = (r_val.sat || r_diag.sat || r_off.sat || r_scale.sat)
                           ? ST_SAT : ST_OK;
            end
            else
            begin
                st_next = r_val.sat ? ST_SAT : ST_OK;
            end
        end
    end

    // stage advance, whole pipeline moves together
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_reg    <= a_next;
            b_reg    <= a_reg;
            b_aa_reg <= aa;
            b_sd_reg <= sd;

            sq_st_reg[0]   <= sq_start;
            sq_meta_reg[0] <= c_meta;
            for (int i = 1; i <= SQ_STEPS; i++)
            begin
                sq_st_reg[i]   <= sqrt_step(sq_st_reg[i-1]);
                sq_meta_reg[i] <= sq_meta_reg[i-1];
            end

            d_meta_reg <= d_meta_next;
            d_f_reg    <= f;
            d_sm_reg   <= sm;
            d_magd_reg <= mag32(sm_meta.d);
            d_dneg_reg <= sm_meta.d[31];
            d_sneg_reg <= sm_meta.s[31];
            d_n_reg    <= n34;
            d_off_reg  <= off34;
            d_fs_reg   <= 64'(f) * 64'(sm);
            d_ss_reg   <= 64'(sm) * 64'(sm);

            dv_meta_reg[0] <= d_meta_reg;
            for (int j = 0; j < DIV_N; j++)
            begin
                dv_reg[0][j] <= dv_start[j];
            end
            for (int i = 1; i <= DIV_STEPS; i++)
            begin
                dv_meta_reg[i] <= dv_meta_reg[i-1];
                for (int j = 0; j < DIV_N; j++)
                begin
                    dv_reg[i][j] <= div_step(dv_reg[i-1][j]);
                end
            end

            o_idx_reg   <= fm.band.k;
            o_val_reg   <= val_next;
            o_diag_reg  <= diag_next;
            o_off_reg   <= off_next;
            o_scale_reg <= scale_next;
            o_st_reg    <= st_next;
            o_last_reg  <= (fm.band.k == 2'd3);
        end
    end

    assign out_valid   = vld_reg[PIPE_N-1];
    assign bound_index = o_idx_reg;
    assign bound_value = o_val_reg;
    assign d_by_diag   = o_diag_reg;
    assign d_by_offset = o_off_reg;
    assign d_by_scale  = o_scale_reg;
    assign status      = o_st_reg;
    assign last        = o_last_reg;

endmodule

`default_nettype wire

/* rtl/dcbb_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module dcbb_checker
    import dcbb_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [1:0]  bound_index,
    input wire logic [31:0] bound_value,
    input wire logic [31:0] d_by_diag,
    input wire logic [31:0] d_by_offset,
    input wire logic [31:0] d_by_scale,
    input wire logic [2:0]  status,
    input wire logic        last
);

    // last marks the ymax result only
    a_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (last == (bound_index == 2'd3)))
        else $error("last does not match bound_index");

    // error codes carry no derivatives
    a_err_deriv: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_ZERO_SCALE || status == ST_NEG_DISC
                      || status == ST_ZERO_ROOT)
        |-> (d_by_diag == 32'd0) && (d_by_offset == 32'd0) && (d_by_scale == 32'd0))
        else $error("derivatives nonzero on error status");

    // no bound without a scale or a real root
    a_err_value: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_ZERO_SCALE || status == ST_NEG_DISC)
        |-> (bound_value == 32'd0))
        else $error("bound value nonzero on error status");

    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready
        |=> out_valid && $stable(bound_index) && $stable(bound_value) && $stable(status))
        else $error("result changed while stalled");

endmodule

bind dual_conic_bounding_box dcbb_checker u_dcbb_checker (.*);

`default_nettype wire

/* test/dual_conic_bounding_box_test.sv */
`timescale 1ns / 1ps

module dual_conic_bounding_box_test;
    import dcbb_pkg::*;

    // bound result as seen on the output channel
    typedef struct {
        logic [1:0]  idx;
        logic [31:0] value;
        logic [31:0] ddiag;
        logic [31:0] doff;
        logic [31:0] dscale;
        logic [2:0]  stat;
        logic        lst;
    } bound_t;

    localparam logic [63:0] MAG_CAP = 64'd1 << 62;
    localparam int LATENCY = 101;
    localparam longint CYCLE_LIMIT = 2000000;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    logic signed [31:0] c00, c11, c02, c12, c22;
    logic want_derivs;
    logic out_valid;
    logic out_ready;
    logic [1:0] bound_index;
    logic signed [31:0] bound_value, d_by_diag, d_by_offset, d_by_scale;
    logic [2:0] status;
    logic last;

    bound_t pending_bounds[$];
    int errors;
    int send_idle_pct;
    int recv_stall_pct;
    longint cycles;

    dual_conic_bounding_box dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .c00(c00), .c11(c11), .c02(c02), .c12(c12), .c22(c22),
        .want_derivs(want_derivs),
        .out_valid(out_valid), .out_ready(out_ready),
        .bound_index(bound_index), .bound_value(bound_value),
        .d_by_diag(d_by_diag), .d_by_offset(d_by_offset),
        .d_by_scale(d_by_scale), .status(status), .last(last)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // floor square root of a 64-bit value
    function automatic logic [63:0] floor_sqrt(input logic [63:0] n);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0)
        begin
            if (n >= r + b)
            begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    // signed truncating quotient of (m << sh) / dv, magnitude clamped to 2^62
    function automatic logic signed [63:0] scaled_quot(input logic [63:0] m,
            input int sh, input logic [63:0] dv, input logic neg);
        logic [127:0] num;
        logic [127:0] q;
        logic [63:0]  mag;
        num = {64'd0, m} << sh;
        q = num / {64'd0, dv};
        mag = (q > {64'd0, MAG_CAP}) ? MAG_CAP : q[63:0];
        return neg ? -$signed(mag) : $signed(mag);
    endfunction

    function automatic logic [31:0] clamp32(input logic signed [63:0] v,
            inout logic sat);
        if (v > 64'sd2147483647)
        begin
            sat = 1'b1;
            return 32'h7FFF_FFFF;
        end
        if (v < -64'sd2147483648)
        begin
            sat = 1'b1;
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

    function automatic logic [63:0] abs64(input logic signed [63:0] v);
        return v < 0 ? -v : v;
    endfunction

    // expected bound for one row of the Jacobian
    function automatic bound_t predict_bound(input logic [1:0] k,
            input logic signed [63:0] d, input logic signed [63:0] a,
            input logic signed [63:0] s, input logic want);
        bound_t o;
        logic signed [63:0] disc, f, n, off, t1, t2;
        logic [63:0] fm, sm;
        logic sat;
        logic is_max;
        is_max = k[1];
        sat = 1'b0;
        o.idx = k;
        o.value = 0;
        o.ddiag = 0;
        o.doff = 0;
        o.dscale = 0;
        o.lst = (k == 2'd3);
        o.stat = ST_OK;
        if (s == 0)
        begin
            o.stat = ST_ZERO_SCALE;
            return o;
        end
        disc = a * a - s * d;
        if (disc < 0)
        begin
            o.stat = ST_NEG_DISC;
            return o;
        end
        fm = floor_sqrt(disc);
        f = $signed(fm);
        sm = abs64(s);
        n = is_max ? a - f : a + f;
        o.value = clamp32(scaled_quot(abs64(n), FRAC_BITS, sm, (n < 0) != (s < 0)), sat);
        if (want)
        begin
            if (f == 0)
            begin
                o.stat = ST_ZERO_ROOT;
                return o;
            end
            o.ddiag = clamp32(scaled_quot(64'd1, 2 * FRAC_BITS - 1, fm, !is_max), sat);
            off = is_max ? f - a : f + a;
            o.doff = clamp32(scaled_quot(abs64(off), 2 * FRAC_BITS, fm * sm,
                    (off < 0) != (s < 0)), sat);
            t1 = scaled_quot(abs64(n), 2 * FRAC_BITS, sm * sm, n > 0);
            t2 = scaled_quot(abs64(d), 2 * FRAC_BITS, 2 * fm * sm,
                    ((d < 0) != (s < 0)) != !is_max);
            o.dscale = clamp32(t1 + t2, sat);
        end
        if (sat) o.stat = ST_SAT;
        return o;
    endfunction

    // send one conic and queue its four bounds
    task automatic send_conic(input logic [31:0] e00, input logic [31:0] e11,
            input logic [31:0] e02, input logic [31:0] e12,
            input logic [31:0] e22, input logic w);
        int k;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        c00 <= e00;
        c11 <= e11;
        c02 <= e02;
        c12 <= e12;
        c22 <= e22;
        want_derivs <= w;
        for (k = 0; k < 4; k++)
            pending_bounds.insert(pending_bounds.size(), predict_bound(k[1:0],
                64'($signed(k[0] ? e11 : e00)), 64'($signed(k[0] ? e12 : e02)),
                64'($signed(e22)), w));
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    task automatic drain_bounds();
        in_valid <= 1'b0;
        while (pending_bounds.size() != 0) @(posedge clk);
    endtask

    // random conic: mostly real ellipse-like entries of moderate size
    task automatic send_random_conic();
        logic [31:0] e[5];
        int sel;
        int i;
        sel = $urandom_range(9);
        for (i = 0; i < 5; i++)
        begin
            if (sel < 2)
                e[i] = $urandom;
            else if (sel < 8)
                e[i] = $signed($urandom_range(8 << FRAC_BITS)) - (4 << FRAC_BITS);
            else
                e[i] = $signed($urandom_range(2000)) - 1000;
        end
        if (sel >= 2 && sel < 8)
        begin
            // make s*d negative so the root is real
            if (e[4][31] == e[0][31]) e[0] = -e[0];
            if (e[4][31] == e[1][31]) e[1] = -e[1];
        end
        if ($urandom_range(30) == 0) e[4] = 0;
        send_conic(e[0], e[1], e[2], e[3], e[4], 1'($urandom_range(1)));
    endtask

    // check every result against the oldest expectation
    always @(posedge clk)
    begin
        bound_t exp_b;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_bounds.size() == 0)
            begin
                $display("%0t unexpected result: idx %0d value %h", $time,
                    bound_index, bound_value);
                errors++;
            end
            else
            begin
                exp_b = pending_bounds.pop_front();
                if (bound_index !== exp_b.idx || bound_value !== exp_b.value ||
                    d_by_diag !== exp_b.ddiag || d_by_offset !== exp_b.doff ||
                    d_by_scale !== exp_b.dscale || status !== exp_b.stat ||
                    last !== exp_b.lst)
                begin
                    $display("%0t mismatch expected idx %0d val %h dd %h do %h ds %h st %0d last %b",
                        $time, exp_b.idx, exp_b.value, exp_b.ddiag, exp_b.doff,
                        exp_b.dscale, exp_b.stat, exp_b.lst);
                    $display("%0t          actual   idx %0d val %h dd %h do %h ds %h st %0d last %b",
                        $time, bound_index, bound_value, d_by_diag, d_by_offset,
                        d_by_scale, status, last);
                    errors++;
                end
            end
        end
    end

    // receiver back-pressure
    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= recv_stall_pct);

    // run limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic test_directed();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        // unit circle at origin: c00=c11=1, c22=-1
        send_conic(32'h0001_0000, 32'h0001_0000, 0, 0, 32'hFFFF_0000, 1'b1);
        send_conic(32'h0001_0000, 32'h0001_0000, 0, 0, 32'hFFFF_0000, 1'b0);
        // zero scale
        send_conic(32'h0001_0000, 32'h0001_0000, 32'h0002_0000, 0, 0, 1'b1);
        // negative discriminant
        send_conic(32'h0001_0000, 32'h0001_0000, 0, 0, 32'h0001_0000, 1'b1);
        // zero root with and without derivatives
        send_conic(0, 0, 0, 0, 32'h0001_0000, 1'b1);
        send_conic(0, 0, 0, 0, 32'h0001_0000, 1'b0);
        // saturation: tiny scale
        send_conic(32'hFFFF_0000, 32'hFFFF_0000, 32'h7FFF_FFFF, 32'h8000_0000,
            32'h0000_0001, 1'b1);
        send_conic(32'hFFFF_0000, 32'hFFFF_0000, 32'h7FFF_FFFF, 32'h8000_0000,
            32'h0000_0001, 1'b0);
        // field extremes
        send_conic(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
            32'h7FFF_FFFF, 1'b1);
        send_conic(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
            32'h8000_0000, 1'b1);
        send_conic(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
            32'hFFFF_FFFF, 1'b1);
        send_conic(32'h8000_0000, 32'h8000_0000, 0, 0, 32'h7FFF_FFFF, 1'b1);
        send_conic(32'h0000_0001, 32'h0000_0001, 32'h0000_0001, 32'h0000_0001,
            32'hFFFF_FFFF, 1'b1);
        // shifted ellipse
        send_conic(32'hFFFD_0000, 32'hFFFE_0000, 32'h0003_0000, 32'hFFFE_8000,
            32'h0001_0000, 1'b1);
        drain_bounds();
    endtask

    task automatic test_random_phase(input int idle, input int stall, input int count);
        int i;
        send_idle_pct = idle;
        recv_stall_pct = stall;
        for (i = 0; i < count; i++) send_random_conic();
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        out_ready = 1'b0;
        c00 = 0;
        c11 = 0;
        c02 = 0;
        c12 = 0;
        c22 = 0;
        want_derivs = 1'b0;
        errors = 0;
        cycles = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random_phase(0, 0, 100);
        test_random_phase(77, 0, 80);
        drain_bounds();
        test_random_phase(0, 77, 80);
        test_random_phase(17, 17, 80);
        test_random_phase(0, 0, 60);
        drain_bounds();
        repeat (LATENCY + 20) @(posedge clk);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
